// File: hdl/gregorian_date_add_period_macros.svh
// assertion helpers used by the asserting top-level file
`ifndef GREGORIAN_DATE_ADD_PERIOD_MACROS_SVH
`define GREGORIAN_DATE_ADD_PERIOD_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define GDAP_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define GDAP_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// File: hdl/gdap_pkg.sv
package gdap_pkg;

    // true year: start year, added years, month carries and peeled days
    localparam int YEAR_W  = 17;
    localparam int OUT_Y_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 8;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0] CYCLE_400 = 17'd400;
    localparam logic [YEAR_W-1:0] YEAR_100  = 17'd100;
    localparam logic [YEAR_W-1:0] YEAR_200  = 17'd200;
    localparam logic [YEAR_W-1:0] YEAR_300  = 17'd300;
    localparam logic [YEAR_W-1:0] YEAR_399  = 17'd399;

    localparam logic [DAY_W-1:0] LEN_31   = 5'd31;
    localparam logic [DAY_W-1:0] LEN_30   = 5'd30;
    localparam logic [DAY_W-1:0] LEN_29   = 5'd29;
    localparam logic [DAY_W-1:0] LEN_28   = 5'd28;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MON,
        S_PEEL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic mon_step;
        logic peel_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ymod_ge;
        logic mcnt_zero;
        logic days_zero;
        logic left_gt_len;
        logic out_free;
    } t_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:                                len = leap ? LEN_29 : LEN_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
            default:                                  len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/gdap_ctrl.sv
module gdap_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gdap_pkg::t_status i_status,
    output logic              o_ready,
    output gdap_pkg::t_cmd    o_cmd
);
    import gdap_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MOD;
            end
            S_MOD: begin
                if (!i_status.ymod_ge) n_state = S_MON;
            end
            S_MON: begin
                if (i_status.mcnt_zero) n_state = i_status.days_zero ? S_FIN : S_PEEL;
            end
            S_PEEL: begin
                if (!i_status.left_gt_len) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                o_ready      = i_rst_n;
                o_cmd.load   = i_valid && i_rst_n;
            end
            S_MOD:  o_cmd.mod_step  = i_status.ymod_ge;
            S_MON:  o_cmd.mon_step  = !i_status.mcnt_zero;
            S_PEEL: o_cmd.peel_step = i_status.left_gt_len;
            S_FIN:  o_cmd.out_load  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/gdap_dp.sv
module gdap_dp #(
    parameter int MAX_YEAR     = 9999,
    parameter int DAY_ADD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gdap_pkg::t_cmd                     i_cmd,
    output gdap_pkg::t_status                  o_status,
    input  logic [13:0]                        i_start_year,
    input  logic [gdap_pkg::MONTH_W-1:0]       i_start_month,
    input  logic [gdap_pkg::DAY_W-1:0]         i_start_day,
    input  logic [7:0]                         i_add_years,
    input  logic [gdap_pkg::CNT_W-1:0]         i_add_months,
    input  logic [15:0]                        i_add_days,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [gdap_pkg::OUT_Y_W-1:0]       o_result_year,
    output logic [gdap_pkg::MONTH_W-1:0]       o_result_month,
    output logic [gdap_pkg::DAY_W-1:0]         o_result_day,
    output logic                               o_year_overflow
);
    import gdap_pkg::*;

    // only the low DAY_ADD_BITS day-count bits (at most the 16 on the port) take part
    localparam int AD_W   = (DAY_ADD_BITS < 16) ? DAY_ADD_BITS : 16;
    localparam int LEFT_W = AD_W + 1;

    logic [YEAR_W-1:0]  r_year;
    logic [YEAR_W-1:0]  r_ymod;
    logic [MONTH_W-1:0] r_month;
    logic [CNT_W-1:0]   r_mcnt;
    logic [LEFT_W-1:0]  r_left;
    logic               r_adz;
    logic [DAY_W-1:0]   r_day;

    logic               r_o_valid;
    logic [OUT_Y_W-1:0] r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DAY_W-1:0]   r_o_day;
    logic               r_o_ovf;

    logic [YEAR_W-1:0]  year_sum;
    logic [MONTH_W-1:0] month_norm;
    logic [AD_W-1:0]    ad_eff;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [YEAR_W-1:0]  n_year;
    logic [YEAR_W-1:0]  n_ymod;
    logic [MONTH_W-1:0] n_month;
    logic               ovf;

    assign year_sum = YEAR_W'(i_start_year) + YEAR_W'(i_add_years);
    assign ad_eff   = i_add_days[AD_W-1:0];

    always_comb begin
        if (i_start_month == '0) begin
            month_norm = MONTH_JAN;
        end else if (i_start_month > MONTH_DEC) begin
            month_norm = MONTH_DEC;
        end else begin
            month_norm = i_start_month;
        end
    end

    // r_ymod stays below 400 once reduction is done
    assign leap = (r_ymod[1:0] == 2'b00) && (r_ymod != YEAR_100) &&
                  (r_ymod != YEAR_200) && (r_ymod != YEAR_300);
    assign len  = month_len(r_month, leap);

    // shared month advance for month stepping and day peeling
    always_comb begin
        n_year  = r_year;
        n_ymod  = r_ymod;
        n_month = r_month + MONTH_W'(1);
        if (r_month >= MONTH_DEC) begin
            n_month = MONTH_JAN;
            n_year  = r_year + YEAR_W'(1);
            n_ymod  = (r_ymod == YEAR_399) ? '0 : r_ymod + YEAR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= year_sum;
            r_ymod  <= year_sum;
            r_month <= month_norm;
            r_mcnt  <= i_add_months;
            r_left  <= LEFT_W'(i_start_day) + LEFT_W'(ad_eff);
            r_adz   <= (ad_eff == '0);
            r_day   <= i_start_day;
        end else if (i_cmd.mod_step) begin
            r_ymod  <= r_ymod - CYCLE_400;
        end else if (i_cmd.mon_step) begin
            r_year  <= n_year;
            r_ymod  <= n_ymod;
            r_month <= n_month;
            r_mcnt  <= r_mcnt - CNT_W'(1);
        end else if (i_cmd.peel_step) begin
            r_year  <= n_year;
            r_ymod  <= n_ymod;
            r_month <= n_month;
            r_left  <= r_left - LEFT_W'(len);
        end
    end

    assign ovf = (r_year > YEAR_W'(MAX_YEAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_year  <= ovf ? OUT_Y_W'(MAX_YEAR) : r_year[OUT_Y_W-1:0];
            r_o_month <= r_month;
            r_o_day   <= r_adz ? r_day : r_left[DAY_W-1:0];
            r_o_ovf   <= ovf;
        end
    end

    assign o_status.ymod_ge     = (r_ymod >= CYCLE_400);
    assign o_status.mcnt_zero   = (r_mcnt == '0);
    assign o_status.days_zero   = r_adz;
    assign o_status.left_gt_len = (r_left > LEFT_W'(len));
    assign o_status.out_free    = !r_o_valid || i_out_ready;

    assign o_out_valid     = r_o_valid;
    assign o_result_year   = r_o_year;
    assign o_result_month  = r_o_month;
    assign o_result_day    = r_o_day;
    assign o_year_overflow = r_o_ovf;

endmodule

// File: hdl/gregorian_date_add_period.sv
// one item at a time: o_ready is high only in idle, after the last result is loaded
// the next item is taken while a finished result waits in the output register
// reset: synchronous active-low i_rst_n clears controller state and output valid
module gregorian_date_add_period #(
    parameter int MAX_YEAR     = 9999,
    parameter int DAY_ADD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [13:0] i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [7:0]  i_add_years,
    input  logic [7:0]  i_add_months,
    input  logic [15:0] i_add_days,
    // result item channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [13:0] o_result_year,
    output logic [3:0]  o_result_month,
    output logic [4:0]  o_result_day,
    output logic        o_year_overflow
);
    import gdap_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd    cmd;
    t_status status;

    // the sequencer walks: load, reduce year mod 400 by repeated subtraction,
    // step months one at a time, peel whole months off a nonzero day count, then
    // hand the date to the output register once that register is free
    gdap_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    // the datapath tracks the true year (wider than the port) and its value
    // mod 400 so the leap test needs no divider; saturation happens only when
    // the result is loaded into the output register
    gdap_dp #(
        .MAX_YEAR     (MAX_YEAR),
        .DAY_ADD_BITS (DAY_ADD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_start_year    (i_start_year),
        .i_start_month   (i_start_month),
        .i_start_day     (i_start_day),
        .i_add_years     (i_add_years),
        .i_add_months    (i_add_months),
        .i_add_days      (i_add_days),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_result_year   (o_result_year),
        .o_result_month  (o_result_month),
        .o_result_day    (o_result_day),
        .o_year_overflow (o_year_overflow)
    );

`include "gregorian_date_add_period_macros.svh"

    // an accepted item keeps the block busy for at least the next cycle
    `GDAP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
                      "input taken while busy")
    // a result is only loaded when the output register can take it
    `GDAP_ASSERT_NOW(a_out_load_free, i_clk, i_rst_n, cmd.out_load, status.out_free,
                     "output register overwritten")
    // a saturated result carries the maximum year
    `GDAP_ASSERT_NOW(a_ovf_year, i_clk, i_rst_n, o_valid && o_year_overflow,
                     o_result_year == 14'(MAX_YEAR), "overflow without saturated year")
    // the month of a result is always a real month
    `GDAP_ASSERT_NOW(a_month_range, i_clk, i_rst_n, o_valid,
                     (o_result_month >= MONTH_JAN) && (o_result_month <= MONTH_DEC),
                     "result month out of range")

endmodule
